@@ hw/rtl/apc_pkg.sv @@
package apc_pkg;

    // Default filter constant and adaptation rate, both Q0.8
    localparam int FILTER_ALPHA_DEF = 128;
    localparam int ADAPT_RATE_DEF   = 26;

    // Serial arithmetic unit widths
    localparam int OP_W   = 26;
    localparam int PROD_W = 2 * OP_W;
    localparam int LEN_W  = 5;
    localparam int DEN_W  = 17;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN_DT   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN_DT   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDFWD_GAIN    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN         = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX         = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WINDUP_LIMIT    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ADAPT_THRESHOLD = 4'd7;

    localparam logic [16:0] THRESH_OFF = 17'h1FFFF;
    localparam logic [9:0]  F_UNITY    = 10'd256;
    localparam logic [9:0]  F_MAX      = 10'd512;

    // Serial step counts of each operation
    localparam logic [LEN_W-1:0] LEN_DIVF  = 5'd26;
    localparam logic [LEN_W-1:0] LEN_MULKP = 5'd10;
    localparam logic [LEN_W-1:0] LEN_DIVKI = 5'd24;
    localparam logic [LEN_W-1:0] LEN_MULKD = 5'd10;
    localparam logic [LEN_W-1:0] LEN_MULP  = 5'd17;
    localparam logic [LEN_W-1:0] LEN_MULI  = 5'd24;
    localparam logic [LEN_W-1:0] LEN_MULF  = 5'd9;
    localparam logic [LEN_W-1:0] LEN_MULD  = 5'd17;
    localparam logic [LEN_W-1:0] LEN_MULFF = 5'd16;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
    } t_unit_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVF,
        S_MULKP,
        S_DIVKI,
        S_MULKD,
        S_MULP,
        S_MULI,
        S_MULF,
        S_MULD,
        S_MULFF,
        S_DONE
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-32:0] top;
        top = v[PROD_W-1:31];
        if (top == '0 || top == '1) begin
            return v[31:0];
        end
        return v[PROD_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
    endfunction

endpackage

@@ hw/rtl/apc_if.sv @@
interface apc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] setpoint;
    logic signed [15:0] measured;
    logic signed [15:0] feedfwd_value;

    modport source (output valid, setpoint, measured, feedfwd_value, input ready);
    modport sink (input valid, setpoint, measured, feedfwd_value, output ready);
endinterface

interface apc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive;
    logic signed [16:0] err_value;
    logic signed [31:0] p_term;
    logic signed [23:0] i_term;
    logic signed [31:0] d_term;
    logic signed [31:0] ff_term;

    modport source (output valid, drive, err_value, p_term, i_term, d_term, ff_term,
                    input ready);
    modport sink (input valid, drive, err_value, p_term, i_term, d_term, ff_term,
                  output ready);
endinterface

interface apc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [apc_pkg::CFG_IDX_W-1:0]     index;
    logic [apc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/adaptive_pid_controller_core.sv @@
// Fixed-point PID controller with anti-windup, filtered derivative on the
// measured value, feed-forward and error-driven gain adaptation.
//
// Channels: i_in takes one sample request (setpoint, measured, feedfwd_value);
// o_out returns one result request per sample (drive, err_value and the four
// terms). i_cfg writes register i at index i; indexes beyond the list drop.
// Write configuration only while no sample is in flight.
//
// Sequencing: one sample at a time. A sample walks through nine
// serial operations on one shift-add multiplier and one restoring divider,
// each running for its own bit count. With the derivative gain zero the
// filter and derivative multiplies are skipped.
//
// Reset: gains, limits and threshold take their defaults; the integral
// accumulator, previous measured value and derivative filter clear to zero.
//
// Stall: a finished result waits in the output register. The next sample is
// accepted meanwhile; its own result holds in the sequencer until the output
// register frees up.
module adaptive_pid_controller_core #(
    parameter int FILTER_ALPHA_Q8 = apc_pkg::FILTER_ALPHA_DEF,
    parameter int ADAPT_RATE_Q8   = apc_pkg::ADAPT_RATE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    apc_in_if.sink     i_in,
    apc_out_if.source  o_out,
    apc_cfg_if.sink    i_cfg
);
    localparam logic [8:0]        ALPHA_C = 9'(256 - FILTER_ALPHA_Q8);
    localparam logic signed [9:0] ALPHA_S = 10'(FILTER_ALPHA_Q8);
    localparam logic [8:0]        RATE_C  = 9'(ADAPT_RATE_Q8);

    // Configuration registers
    logic [15:0]        r_prop_gain;
    logic [15:0]        r_integ_gain;
    logic [15:0]        r_deriv_gain;
    logic [15:0]        r_ff_gain;
    logic signed [15:0] r_out_min;
    logic signed [15:0] r_out_max;
    logic [14:0]        r_windup;
    logic [16:0]        r_thresh;

    // Sequencer
    apc_pkg::t_state    r_state, n_state;
    logic               r_wait, n_wait;
    apc_pkg::t_unit_req mul_req, div_req;

    // Per-sample working registers
    logic signed [16:0] r_err;
    logic [16:0]        r_aerr;
    logic signed [15:0] r_pv;
    logic signed [15:0] r_fv;
    logic signed [34:0] r_sum;
    logic [9:0]         r_f;
    logic [16:0]        r_kp;
    logic [23:0]        r_ki;
    logic [16:0]        r_kd;
    logic signed [31:0] r_p;
    logic signed [31:0] r_d;
    logic signed [31:0] r_ff;

    // Controller state
    logic signed [23:0] r_i;
    logic signed [15:0] r_prev;
    logic signed [25:0] r_df;

    // Output register
    logic               r_o_valid;
    logic signed [15:0] r_o_drive;
    logic signed [16:0] r_o_err;
    logic signed [31:0] r_o_p;
    logic signed [23:0] r_o_i;
    logic signed [31:0] r_o_d;
    logic signed [31:0] r_o_ff;

    // Unit connections
    logic signed [apc_pkg::OP_W-1:0]   mul_a;
    logic [apc_pkg::OP_W-1:0]          mul_b;
    logic                              mul_done;
    logic signed [apc_pkg::PROD_W-1:0] mul_p;
    logic [apc_pkg::OP_W-1:0]          div_n;
    logic [apc_pkg::DEN_W-1:0]         div_d;
    logic                              div_done;
    logic [apc_pkg::OP_W-1:0]          div_q;

    // Datapath helpers
    logic                              in_accept;
    logic                              cap;
    logic                              out_free;
    logic signed [16:0]                err_in;
    logic [16:0]                       t_eff;
    logic                              adapt;
    logic                              use2;
    logic [16:0]                       excess;
    logic [apc_pkg::OP_W-1:0]          numer;
    logic signed [apc_pkg::OP_W-1:0]   err_ext;
    logic signed [16:0]                dm;
    logic signed [26:0]                dm_a;
    logic signed [apc_pkg::PROD_W-1:0] acc;
    logic signed [apc_pkg::PROD_W-1:0] lim;
    logic signed [23:0]                i_new;
    logic signed [apc_pkg::PROD_W-1:0] prod_sh;
    logic signed [25:0]                df_new;
    logic signed [31:0]                p_sat;
    logic signed [31:0]                d_sat;
    logic signed [34:0]                s_sh;
    logic signed [34:0]                s_lo;
    logic signed [34:0]                s_clamp;

    apc_ser_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    apc_ser_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_n),
        .i_den   (div_d),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    assign i_in.ready  = (r_state == apc_pkg::S_IDLE);
    assign in_accept   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cap         = r_wait && (mul_done || div_done);
    assign out_free    = !r_o_valid || o_out.ready;

    // Error and adaptation decision
    assign err_in  = {i_in.setpoint[15], i_in.setpoint} - {i_in.measured[15], i_in.measured};
    assign t_eff   = (r_thresh == '0) ? 17'd1 : r_thresh;
    assign adapt   = (r_thresh != apc_pkg::THRESH_OFF) && (r_aerr > t_eff);
    assign use2    = adapt && ({1'b0, r_aerr} > {t_eff, 1'b0});
    assign excess  = r_aerr - t_eff;
    assign numer   = adapt ? ({9'b0, excess} * {17'b0, RATE_C}) : '0;
    assign err_ext = {{(apc_pkg::OP_W-17){r_err[16]}}, r_err};

    // Integral update with windup clamp
    assign lim = {{(apc_pkg::PROD_W-23){1'b0}}, r_windup, 8'b0};
    assign acc = {{(apc_pkg::PROD_W-24){r_i[23]}}, r_i} + mul_p;
    always_comb begin
        if (r_integ_gain == '0) begin
            i_new = r_i;
        end else if (acc > lim) begin
            i_new = lim[23:0];
        end else if (acc < -lim) begin
            i_new = 24'(-lim);
        end else begin
            i_new = acc[23:0];
        end
    end

    // Derivative filter and terms
    assign dm      = {r_pv[15], r_pv} - {r_prev[15], r_prev};
    assign dm_a    = 27'(dm) * 27'(ALPHA_S);
    assign prod_sh = mul_p >>> 8;
    assign df_new  = prod_sh[25:0] + dm_a[25:0];
    assign p_sat   = apc_pkg::sat32(mul_p);
    assign d_sat   = apc_pkg::sat32(-prod_sh);

    // Output sum: raise to out_min, then lower to out_max
    assign s_sh    = r_sum >>> 8;
    assign s_lo    = (s_sh < 35'(r_out_min)) ? 35'(r_out_min) : s_sh;
    assign s_clamp = (s_lo > 35'(r_out_max)) ? 35'(r_out_max) : s_lo;

    // Operand selection for the serial units
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        div_n = '0;
        div_d = '0;
        case (r_state)
            apc_pkg::S_DIVF: begin
                div_n = numer;
                div_d = t_eff;
            end
            apc_pkg::S_MULKP: begin
                mul_a = {10'b0, r_prop_gain};
                mul_b = {r_f, 16'b0};
            end
            apc_pkg::S_DIVKI: begin
                div_n = {r_integ_gain, 10'b0};
                div_d = {7'b0, r_f};
            end
            apc_pkg::S_MULKD: begin
                mul_a = {10'b0, r_deriv_gain};
                mul_b = {r_f, 16'b0};
            end
            apc_pkg::S_MULP: begin
                mul_a = err_ext;
                mul_b = {r_kp, 9'b0};
            end
            apc_pkg::S_MULI: begin
                mul_a = err_ext;
                mul_b = {r_ki, 2'b0};
            end
            apc_pkg::S_MULF: begin
                mul_a = r_df;
                mul_b = {ALPHA_C, 17'b0};
            end
            apc_pkg::S_MULD: begin
                mul_a = r_df;
                mul_b = {r_kd, 9'b0};
            end
            apc_pkg::S_MULFF: begin
                mul_a = {{10{r_fv[15]}}, r_fv};
                mul_b = {r_ff_gain, 10'b0};
            end
            default: begin
            end
        endcase
    end

    // Next state: launch the unit on entry, advance when it reports done
    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        mul_req = '0;
        div_req = '0;
        case (r_state)
            apc_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = apc_pkg::S_DIVF;
                end
            end
            apc_pkg::S_DIVF, apc_pkg::S_DIVKI: begin
                if (!r_wait) begin
                    div_req.start = 1'b1;
                    div_req.len   = (r_state == apc_pkg::S_DIVF) ? apc_pkg::LEN_DIVF
                                                                 : apc_pkg::LEN_DIVKI;
                    n_wait        = 1'b1;
                end else if (div_done) begin
                    n_wait  = 1'b0;
                    n_state = (r_state == apc_pkg::S_DIVF) ? apc_pkg::S_MULKP
                                                           : apc_pkg::S_MULKD;
                end
            end
            apc_pkg::S_MULKP, apc_pkg::S_MULKD, apc_pkg::S_MULP, apc_pkg::S_MULI,
            apc_pkg::S_MULF, apc_pkg::S_MULD, apc_pkg::S_MULFF: begin
                if (!r_wait) begin
                    mul_req.start = 1'b1;
                    n_wait        = 1'b1;
                    case (r_state)
                        apc_pkg::S_MULKP: mul_req.len = apc_pkg::LEN_MULKP;
                        apc_pkg::S_MULKD: mul_req.len = apc_pkg::LEN_MULKD;
                        apc_pkg::S_MULP:  mul_req.len = apc_pkg::LEN_MULP;
                        apc_pkg::S_MULI:  mul_req.len = apc_pkg::LEN_MULI;
                        apc_pkg::S_MULF:  mul_req.len = apc_pkg::LEN_MULF;
                        apc_pkg::S_MULD:  mul_req.len = apc_pkg::LEN_MULD;
                        default:          mul_req.len = apc_pkg::LEN_MULFF;
                    endcase
                end else if (mul_done) begin
                    n_wait = 1'b0;
                    case (r_state)
                        apc_pkg::S_MULKP: n_state = apc_pkg::S_DIVKI;
                        apc_pkg::S_MULKD: n_state = apc_pkg::S_MULP;
                        apc_pkg::S_MULP:  n_state = apc_pkg::S_MULI;
                        apc_pkg::S_MULI:  n_state = (r_deriv_gain != '0) ? apc_pkg::S_MULF
                                                                         : apc_pkg::S_MULFF;
                        apc_pkg::S_MULF:  n_state = apc_pkg::S_MULD;
                        apc_pkg::S_MULD:  n_state = apc_pkg::S_MULFF;
                        default:          n_state = apc_pkg::S_DONE;
                    endcase
                end
            end
            apc_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = apc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = apc_pkg::S_IDLE;
                n_wait  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apc_pkg::S_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
    end

    // Configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= 16'd256;
            r_integ_gain <= '0;
            r_deriv_gain <= '0;
            r_ff_gain    <= '0;
            r_out_min    <= 16'sh8000;
            r_out_max    <= 16'sh7FFF;
            r_windup     <= 15'h7FFF;
            r_thresh     <= apc_pkg::THRESH_OFF;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                apc_pkg::REG_PROP_GAIN:       r_prop_gain  <= i_cfg.data[15:0];
                apc_pkg::REG_INTEG_GAIN_DT:   r_integ_gain <= i_cfg.data[15:0];
                apc_pkg::REG_DERIV_GAIN_DT:   r_deriv_gain <= i_cfg.data[15:0];
                apc_pkg::REG_FEEDFWD_GAIN:    r_ff_gain    <= i_cfg.data[15:0];
                apc_pkg::REG_OUT_MIN:         r_out_min    <= i_cfg.data[15:0];
                apc_pkg::REG_OUT_MAX:         r_out_max    <= i_cfg.data[15:0];
                apc_pkg::REG_WINDUP_LIMIT:    r_windup     <= i_cfg.data[14:0];
                apc_pkg::REG_ADAPT_THRESHOLD: r_thresh     <= i_cfg.data[16:0];
                default: begin
                end
            endcase
        end
    end

    // Controller state and adapted factor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i    <= '0;
            r_prev <= '0;
            r_df   <= '0;
            r_f    <= apc_pkg::F_UNITY;
        end else begin
            if (cap && r_state == apc_pkg::S_DIVF) begin
                if (!adapt) begin
                    r_f <= apc_pkg::F_UNITY;
                end else if (div_q[apc_pkg::OP_W-1:8] != '0) begin
                    r_f <= apc_pkg::F_MAX;
                end else begin
                    r_f <= {2'b01, div_q[7:0]};
                end
            end
            if (cap && r_state == apc_pkg::S_MULI) begin
                r_i <= i_new;
            end
            if (cap && r_state == apc_pkg::S_MULF) begin
                r_df <= df_new;
            end
            if (r_state == apc_pkg::S_DONE && out_free) begin
                r_prev <= r_pv;
            end
        end
    end

    // Per-sample datapath captures
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_err  <= err_in;
            r_aerr <= err_in[16] ? 17'(-err_in) : 17'(err_in);
            r_pv   <= i_in.measured;
            r_fv   <= i_in.feedfwd_value;
            r_sum  <= '0;
            r_d    <= '0;
        end else if (cap) begin
            case (r_state)
                apc_pkg::S_MULKP: r_kp <= mul_p[24:8];
                apc_pkg::S_DIVKI: r_ki <= div_q[23:0];
                apc_pkg::S_MULKD: r_kd <= use2 ? mul_p[24:8] : {1'b0, r_deriv_gain};
                apc_pkg::S_MULP: begin
                    r_p   <= p_sat;
                    r_sum <= r_sum + 35'(p_sat);
                end
                apc_pkg::S_MULI: begin
                    r_sum <= r_sum + 35'(i_new);
                end
                apc_pkg::S_MULD: begin
                    r_d   <= d_sat;
                    r_sum <= r_sum + 35'(d_sat);
                end
                apc_pkg::S_MULFF: begin
                    r_ff  <= mul_p[31:0];
                    r_sum <= r_sum + 35'($signed(mul_p[31:0]));
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == apc_pkg::S_DONE && out_free) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == apc_pkg::S_DONE && out_free) begin
            r_o_drive <= s_clamp[15:0];
            r_o_err   <= r_err;
            r_o_p     <= r_p;
            r_o_i     <= r_i;
            r_o_d     <= r_d;
            r_o_ff    <= r_ff;
        end
    end

    assign o_out.valid     = r_o_valid;
    assign o_out.drive     = r_o_drive;
    assign o_out.err_value = r_o_err;
    assign o_out.p_term    = r_o_p;
    assign o_out.i_term    = r_o_i;
    assign o_out.d_term    = r_o_d;
    assign o_out.ff_term   = r_o_ff;

    a_mul_done_in_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> r_wait && (r_state == apc_pkg::S_MULKP || r_state == apc_pkg::S_MULKD ||
            r_state == apc_pkg::S_MULP || r_state == apc_pkg::S_MULI ||
            r_state == apc_pkg::S_MULF || r_state == apc_pkg::S_MULD ||
            r_state == apc_pkg::S_MULFF))
        else $error("multiplier finished outside a multiply step");

    a_div_done_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_wait && (r_state == apc_pkg::S_DIVF || r_state == apc_pkg::S_DIVKI))
        else $error("divider finished outside a divide step");

    a_factor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f >= apc_pkg::F_UNITY && r_f <= apc_pkg::F_MAX)
        else $error("adapt factor out of range");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == apc_pkg::S_IDLE |-> !r_wait)
        else $error("unit request pending while idle");

    a_drive_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_o_drive <= r_out_max)
        else $error("drive above upper clamp");
endmodule

@@ hw/rtl/apc_ser_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle, MSB first.
// The multiplier operand arrives left-aligned; len bits are consumed.
module apc_ser_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  apc_pkg::t_unit_req                  i_req,
    input  logic signed [apc_pkg::OP_W-1:0]     i_a,
    input  logic [apc_pkg::OP_W-1:0]            i_b,
    output logic                                o_done,
    output logic signed [apc_pkg::PROD_W-1:0]   o_prod
);
    logic [apc_pkg::LEN_W-1:0]          r_cnt;
    logic                               r_done;
    logic signed [apc_pkg::OP_W-1:0]    r_a;
    logic [apc_pkg::OP_W-1:0]           r_b;
    logic signed [apc_pkg::PROD_W-1:0]  r_p;
    logic signed [apc_pkg::PROD_W-1:0]  addend;

    assign addend = r_b[apc_pkg::OP_W-1]
                  ? {{(apc_pkg::PROD_W-apc_pkg::OP_W){r_a[apc_pkg::OP_W-1]}}, r_a}
                  : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= i_req.len;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == apc_pkg::LEN_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_cnt != '0) begin
            r_p <= (r_p <<< 1) + addend;
            r_b <= r_b << 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;
endmodule

@@ hw/rtl/apc_ser_div.sv @@
// Restoring divider, one quotient bit per cycle.
// The dividend arrives left-aligned; len quotient bits are produced.
module apc_ser_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  apc_pkg::t_unit_req               i_req,
    input  logic [apc_pkg::OP_W-1:0]         i_num,
    input  logic [apc_pkg::DEN_W-1:0]        i_den,
    output logic                             o_done,
    output logic [apc_pkg::OP_W-1:0]         o_quo
);
    logic [apc_pkg::LEN_W-1:0]  r_cnt;
    logic                       r_done;
    logic [apc_pkg::OP_W-1:0]   r_n;
    logic [apc_pkg::DEN_W-1:0]  r_d;
    logic [apc_pkg::DEN_W-1:0]  r_rem;
    logic [apc_pkg::OP_W-1:0]   r_q;
    logic [apc_pkg::DEN_W:0]    trial;
    logic [apc_pkg::DEN_W:0]    diff;
    logic                       ge;

    assign trial = {r_rem, r_n[apc_pkg::OP_W-1]};
    assign diff  = trial - {1'b0, r_d};
    assign ge    = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= i_req.len;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == apc_pkg::LEN_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_n   <= i_num;
            r_d   <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[apc_pkg::DEN_W-1:0] : trial[apc_pkg::DEN_W-1:0];
            r_q   <= {r_q[apc_pkg::OP_W-2:0], ge};
            r_n   <= r_n << 1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

@@ bench/adaptive_pid_controller_core_tb.sv @@
module adaptive_pid_controller_core_tb;

    typedef struct {
        logic signed [15:0] setpoint;
        logic signed [15:0] measured;
        logic signed [15:0] feedfwd_value;
    } t_sample;

    typedef struct {
        logic signed [15:0] drive;
        logic signed [16:0] err_value;
        logic signed [31:0] p_term;
        logic signed [23:0] i_term;
        logic signed [31:0] d_term;
        logic signed [31:0] ff_term;
    } t_control;

    typedef struct {
        logic                           is_cfg;
        logic [apc_pkg::CFG_IDX_W-1:0]  index;
        logic [apc_pkg::CFG_DATA_W-1:0] data;
        t_sample                        smp;
    } t_request;

    localparam int ALPHA      = apc_pkg::FILTER_ALPHA_DEF;
    localparam int RATE       = apc_pkg::ADAPT_RATE_DEF;
    localparam int SETTLE     = 400;
    localparam int CYCLE_CAP  = 2500000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    apc_in_if  in_ch ();
    apc_out_if out_ch ();
    apc_cfg_if cfg_ch ();

    adaptive_pid_controller_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the configuration and state
    longint gain_p, gain_i, gain_d, gain_ff, lim_lo, lim_hi, windup, thresh;
    longint acc_q8, last_meas, dfilt_q8;

    t_request request_q[$];   // filled up front, consumed by the driver
    t_control control_q[$];   // expected results, oldest first
    int       errors = 0;
    int       samples_sent = 0;
    int       results_seen = 0;
    int       cfg_writes = 0;
    int       cycles = 0;
    logic     quiet_tail = 1'b0;
    logic     stim_done = 1'b0;

    function automatic longint floor256(longint v);
        return v >>> 8;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void apply_register(logic [apc_pkg::CFG_IDX_W-1:0] idx,
                                           logic [apc_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            apc_pkg::REG_PROP_GAIN:       gain_p = val[15:0];
            apc_pkg::REG_INTEG_GAIN_DT:   gain_i = val[15:0];
            apc_pkg::REG_DERIV_GAIN_DT:   gain_d = val[15:0];
            apc_pkg::REG_FEEDFWD_GAIN:    gain_ff = val[15:0];
            apc_pkg::REG_OUT_MIN:         lim_lo = $signed(val[15:0]);
            apc_pkg::REG_OUT_MAX:         lim_hi = $signed(val[15:0]);
            apc_pkg::REG_WINDUP_LIMIT:    windup = val[14:0];
            apc_pkg::REG_ADAPT_THRESHOLD: thresh = val[16:0];
            default: ;
        endcase
    endfunction

    // Compute one controller step and advance the state
    function automatic t_control pid_step(t_sample s);
        t_control r;
        longint err, aerr, kp, ki, kd, kiq, t, f, p, i, d, ff, sum, lim, acc, dm;
        err = longint'(s.setpoint) - longint'(s.measured);
        aerr = err < 0 ? -err : err;
        kp = gain_p;
        ki = gain_i << 8;
        kd = gain_d;
        kiq = 256;
        t = thresh == 0 ? 1 : thresh;
        if (thresh != 131071 && aerr > t) begin
            f = 256 + ((aerr - t) * RATE) / t;
            if (f < 256) f = 256;
            if (f > 512) f = 512;
            kp = (kp * f) >>> 8;
            kiq = f;
            if (aerr > 2 * t) kd = (kd * f) >>> 8;
        end
        ki = ki / kiq;
        p = clip32(err * kp);
        if (gain_i != 0) begin
            lim = windup << 8;
            acc = acc_q8 + err * ki;
            if (acc > lim) acc = lim;
            if (acc < -lim) acc = -lim;
            acc_q8 = longint'($signed(acc[31:0]));
        end
        i = acc_q8;
        if (gain_d != 0) begin
            dm = longint'(s.measured) - last_meas;
            dfilt_q8 = longint'($signed(
                floor256(dfilt_q8 * (256 - ALPHA) + dm * 256 * ALPHA) & 64'hFFFFFFFF));
            dfilt_q8 = longint'($signed(dfilt_q8[31:0]));
            d = clip32(-floor256(kd * dfilt_q8));
        end else begin
            d = 0;
        end
        last_meas = s.measured;
        ff = gain_ff * longint'(s.feedfwd_value);
        sum = floor256(p + i + d + ff);
        if (sum < lim_lo) sum = lim_lo;
        if (sum > lim_hi) sum = lim_hi;
        r.drive = sum[15:0];
        r.err_value = err[16:0];
        r.p_term = p[31:0];
        r.i_term = i[23:0];
        r.d_term = d[31:0];
        r.ff_term = ff[31:0];
        return r;
    endfunction

    function automatic void push_cfg(logic [apc_pkg::CFG_IDX_W-1:0] idx, longint val);
        t_request q;
        q.is_cfg = 1'b1;
        q.index = idx;
        q.data = val[apc_pkg::CFG_DATA_W-1:0];
        q.smp = '{0, 0, 0};
        request_q.push_back(q);
    endfunction

    function automatic void push_sample(longint sp, longint pv, longint fv);
        t_request q;
        q.is_cfg = 1'b0;
        q.index = '0;
        q.data = '0;
        q.smp.setpoint = sp[15:0];
        q.smp.measured = pv[15:0];
        q.smp.feedfwd_value = fv[15:0];
        request_q.push_back(q);
    endfunction

    function automatic longint rnd16();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return 32767;
            2: return $signed(16'($urandom_range(0, 65535)));
            default: return $signed(16'($urandom_range(0, 1023))) - 512;
        endcase
    endfunction

    // Pick a random register setting, extremes included
    function automatic void push_random_setting();
        longint lo, hi;
        push_cfg(apc_pkg::REG_PROP_GAIN, $urandom_range(0, 3) == 0 ?
                 (($urandom_range(0, 1) == 1) ? 65535 : 0) : $urandom_range(0, 65535));
        push_cfg(apc_pkg::REG_INTEG_GAIN_DT, $urandom_range(0, 3) == 0 ? 0 :
                 ($urandom_range(0, 1) ? 65535 : $urandom_range(1, 2048)));
        push_cfg(apc_pkg::REG_DERIV_GAIN_DT,
                 $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 65535));
        push_cfg(apc_pkg::REG_FEEDFWD_GAIN, $urandom_range(0, 65535));
        lo = rnd16();
        hi = rnd16();
        if ($urandom_range(0, 7) != 0 && lo > hi) begin
            longint tmp;
            tmp = lo;
            lo = hi;
            hi = tmp;
        end
        push_cfg(apc_pkg::REG_OUT_MIN, lo);
        push_cfg(apc_pkg::REG_OUT_MAX, hi);
        push_cfg(apc_pkg::REG_WINDUP_LIMIT,
                 $urandom_range(0, 3) == 0 ? 32767 : $urandom_range(0, 32767));
        case ($urandom_range(0, 4))
            0: push_cfg(apc_pkg::REG_ADAPT_THRESHOLD, 131071);
            1: push_cfg(apc_pkg::REG_ADAPT_THRESHOLD, 0);
            2: push_cfg(apc_pkg::REG_ADAPT_THRESHOLD, $urandom_range(1, 131070));
            default: push_cfg(apc_pkg::REG_ADAPT_THRESHOLD, $urandom_range(1, 4000));
        endcase
        if ($urandom_range(0, 3) == 0) push_cfg(4'd8 + 4'($urandom_range(0, 7)), $urandom);
    endfunction

    // Build the request list: directed part, then random phases
    initial begin
        int phase_len;
        push_sample(0, 0, 0);
        push_sample(32767, -32768, 32767);
        push_sample(-32768, 32767, -32768);
        push_cfg(apc_pkg::REG_INTEG_GAIN_DT, 65535);
        push_cfg(apc_pkg::REG_DERIV_GAIN_DT, 65535);
        push_cfg(apc_pkg::REG_FEEDFWD_GAIN, 65535);
        push_cfg(apc_pkg::REG_PROP_GAIN, 65535);
        push_cfg(apc_pkg::REG_WINDUP_LIMIT, 100);
        push_cfg(apc_pkg::REG_ADAPT_THRESHOLD, 1000);
        push_sample(32767, -32768, 32767);
        push_sample(-32768, 32767, -32768);
        push_sample(1500, 0, 10);
        push_sample(2500, 0, -10);
        push_sample(500, 0, 0);
        push_cfg(apc_pkg::REG_ADAPT_THRESHOLD, 0);
        push_sample(3, 0, 0);
        push_sample(-3, 5, 0);
        push_cfg(apc_pkg::REG_OUT_MIN, 100);
        push_cfg(apc_pkg::REG_OUT_MAX, -100);
        push_sample(1000, 0, 0);
        push_sample(-1000, 0, 0);
        push_cfg(apc_pkg::REG_WINDUP_LIMIT, 0);
        push_cfg(apc_pkg::REG_ADAPT_THRESHOLD, 1);
        push_sample(7, 3, 1);
        push_cfg(4'd15, 17'h1FFFF);
        push_sample(-7, 3, 1);
        while (samples_sent < 0 || request_q.size() < 2200) begin
            push_random_setting();
            phase_len = $urandom_range(20, 120);
            repeat (phase_len) begin
                if ($urandom_range(0, 2) == 0) push_sample(rnd16(), rnd16(), rnd16());
                else push_sample($signed(16'($urandom_range(0, 65535))),
                                 $signed(16'($urandom_range(0, 65535))),
                                 $signed(16'($urandom_range(0, 65535))));
            end
        end
    end

    // Driver: samples flow freely, config writes wait for an idle block
    int   in_gap = 0;
    int   settle = 0;
    logic cfg_busy = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            cfg_ch.valid <= 1'b0;
            in_ch.setpoint <= '0;
            in_ch.measured <= '0;
            in_ch.feedfwd_value <= '0;
            cfg_ch.index <= '0;
            cfg_ch.data <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                control_q.push_back(pid_step(request_q[0].smp));
                void'(request_q.pop_front());
                samples_sent++;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                apply_register(request_q[0].index, request_q[0].data);
                void'(request_q.pop_front());
                cfg_writes++;
            end
            quiet_tail <= request_q.size() < 200;
            if ((in_ch.valid && !in_ch.ready) || (cfg_ch.valid && !cfg_ch.ready)) begin
                // hold the pending request
            end else if (request_q.size() == 0) begin
                in_ch.valid <= 1'b0;
                cfg_ch.valid <= 1'b0;
                stim_done <= 1'b1;
            end else if (request_q[0].is_cfg) begin
                in_ch.valid <= 1'b0;
                if (control_q.size() != 0 || in_ch.valid) begin
                    cfg_ch.valid <= 1'b0;
                    settle <= SETTLE;
                end else if (settle != 0) begin
                    cfg_ch.valid <= 1'b0;
                    settle <= settle - 1;
                end else begin
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.index <= request_q[0].index;
                    cfg_ch.data <= request_q[0].data;
                end
            end else begin
                cfg_ch.valid <= 1'b0;
                if (in_gap != 0) begin
                    in_ch.valid <= 1'b0;
                    in_gap <= in_gap - 1;
                end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                    in_ch.valid <= 1'b0;
                    in_gap <= $urandom_range(0, 10);
                end else begin
                    in_ch.valid <= 1'b1;
                    in_ch.setpoint <= request_q[0].smp.setpoint;
                    in_ch.measured <= request_q[0].smp.measured;
                    in_ch.feedfwd_value <= request_q[0].smp.feedfwd_value;
                end
            end
        end
    end

    // Monitor: stall the result side in bursts, compare each accepted result
    int out_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (control_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result drive=%0d", $time, out_ch.drive);
                end else begin
                    t_control e;
                    e = control_q.pop_front();
                    if (e.drive !== out_ch.drive || e.err_value !== out_ch.err_value ||
                        e.p_term !== out_ch.p_term || e.i_term !== out_ch.i_term ||
                        e.d_term !== out_ch.d_term || e.ff_term !== out_ch.ff_term) begin
                        errors++;
                        $display("%0t: expected drive=%0d err=%0d p=%0d i=%0d d=%0d ff=%0d",
                                 $time, e.drive, e.err_value, e.p_term, e.i_term,
                                 e.d_term, e.ff_term);
                        $display("%0t: actual   drive=%0d err=%0d p=%0d i=%0d d=%0d ff=%0d",
                                 $time, out_ch.drive, out_ch.err_value, out_ch.p_term,
                                 out_ch.i_term, out_ch.d_term, out_ch.ff_term);
                    end
                end
            end
            if (out_gap != 0) begin
                out_ch.ready <= 1'b0;
                out_gap <= out_gap - 1;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                out_gap <= $urandom_range(0, 10);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Reset, drain, settle, report
    initial begin
        in_ch.valid = 1'b0;
        in_ch.setpoint = '0;
        in_ch.measured = '0;
        in_ch.feedfwd_value = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        gain_p = 256; gain_i = 0; gain_d = 0; gain_ff = 0;
        lim_lo = -32768; lim_hi = 32767; windup = 32767; thresh = 131071;
        acc_q8 = 0; last_meas = 0; dfilt_q8 = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && control_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        $display("Ran %0d samples and %0d register writes; %0d results checked.",
                 samples_sent, cfg_writes, results_seen);
        if (errors == 0 && control_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Timed out after %0d cycles.", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
